/* rtl/core/multichannel_sample_mixer_defines.svh */
// Assertion macros shared by the sample mixer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MULTICHANNEL_SAMPLE_MIXER_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_MIXER_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define MSM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define MSM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/msm_pkg.sv */
// Shared types and constants of the multichannel sample mixer.
// No dependencies; imported by the mixer core, its divider and its checker.
`timescale 1ns / 1ps

package msm_pkg;

  localparam int ADDR_W    = 14;
  localparam int LEN_W     = 15;
  localparam int SMP_W     = 8;
  localparam int VOL_W     = 8;
  localparam int CNT_CFG_W = 4;
  // Mix sum and divisor widths cover the largest supported channel count (32).
  localparam int SUM_W     = 21;
  localparam int DIV_W     = 13;
  localparam int QUO_STEPS = 9;

  localparam logic [VOL_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [3:0] OP_TICK       = 4'd0;
  localparam logic [3:0] OP_WRITE      = 4'd1;
  localparam logic [3:0] OP_PLAY       = 4'd2;
  localparam logic [3:0] OP_STOP       = 4'd3;
  localparam logic [3:0] OP_PAUSE      = 4'd4;
  localparam logic [3:0] OP_RESUME     = 4'd5;
  localparam logic [3:0] OP_STOP_ALL   = 4'd6;
  localparam logic [3:0] OP_PAUSE_ALL  = 4'd7;
  localparam logic [3:0] OP_RESUME_ALL = 4'd8;
  localparam logic [3:0] OP_SET_VOLUME = 4'd9;
  localparam logic [3:0] OP_QUERY      = 4'd10;

  localparam logic [1:0] CH_STOPPED = 2'd0;
  localparam logic [1:0] CH_PLAYING = 2'd1;
  localparam logic [1:0] CH_PAUSED  = 2'd2;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [2:0]        channel;
    logic [ADDR_W-1:0] sample_address;
    logic [LEN_W-1:0]  sample_length;
    logic              repeat_req;
    logic [SMP_W-1:0]  sample_value;
    logic [VOL_W-1:0]  volume;
  } req_t;

  typedef struct packed {
    logic [7:0] dac_level;
    logic [1:0] channel_state;
    logic       changed;
    logic       running;
  } rsp_t;

endpackage

/* rtl/core/msm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the sample store and the channel table.
`timescale 1ns / 1ps

module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/msm_div.sv */
// Restoring divider for the mix level: one quotient bit per cycle, saturated at 255.
// Depends on msm_pkg for the sum and divisor widths.
`timescale 1ns / 1ps

module msm_div import msm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);

  localparam int STEP_W = $clog2(QUO_STEPS);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsh;
  logic [QUO_STEPS-1:0] quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUO_STEPS - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // The divisor starts shifted up by the top quotient bit and walks down one bit a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= SUM_W'({divisor, 8'b0});
      quo <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QUO_STEPS-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_STEPS-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign quotient = quo[QUO_STEPS-1] ? 8'hFF : quo[7:0];

endmodule

/* rtl/core/multichannel_sample_mixer.sv */
// Multichannel 8-bit sample player and mixer driving an 8-bit DAC level.
// Depends on msm_pkg, msm_ram and msm_div.
//
// Requests arrive on req (valid/stall) and every request gives exactly one response
// on rsp (valid/stall). Samples are written into a sample RAM; per-channel sound
// pointers, lengths and volumes live in a channel table RAM. One request is worked
// at a time; the next one is taken as soon as the result is parked in the output
// register, even while the receiver stalls that result.
// Simple commands and writes go from execution straight to the response. Play and
// set volume add a channel table read-modify-write, and the all-channel commands
// walk the n channels in use, where n is the channel count in use. A mixing tick
// walks the channel table one entry per cycle (one read port), drains a 3-stage
// pipeline and then runs a restoring divide by 255 * n.
// A tick with no playing channel takes the simple path.
// Reset stops all channels, sets every volume to full scale, the channel count to 8
// and the DAC level to 0; sample and sound contents stay undefined until written.
// A stalled response holds its value; no further response is produced until it
// has been taken.
`timescale 1ns / 1ps

module multichannel_sample_mixer import msm_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_DEPTH = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CNT_CFG_W-1:0] cfg_wr_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp
);

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int RW = AW + 6;
  localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLE_DEPTH - 1);
  localparam logic [5:0]    MAXC6     = 6'(MAX_CHANNELS);

  typedef struct packed {
    logic [AW-1:0]    ptr;
    logic [AW-1:0]    start;
    logic [LEN_W-1:0] length;
    logic             loops;
    logic [LEN_W-1:0] pos;
    logic [VOL_W-1:0] vol;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_RMW   = 8'b0000_0100,
    S_ALL   = 8'b0000_1000,
    S_TICK  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Reduces a 14-bit address modulo the sample depth, for quotients up to 63.
  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
    logic [RW-1:0] r;
    r = RW'(a);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (RW'(SAMPLE_DEPTH) << k)) begin
        r = r - (RW'(SAMPLE_DEPTH) << k);
      end
    end
    return AW'(r);
  endfunction

  state_t                 state;
  req_t                   req_q;
  logic                   changed_q;
  logic [CNT_CFG_W-1:0]   channel_count;
  logic [MAX_CHANNELS-1:0] playing;
  logic [MAX_CHANNELS-1:0] paused;
  logic [MAX_CHANNELS-1:0] vol_set;
  logic [NW-1:0]          play_cnt;
  logic [7:0]             dac_hold;
  logic [NW-1:0]          idx;
  logic [SUM_W-1:0]       sum;

  // Tick pipeline: table read, sample read, multiply, accumulate.
  logic                   a_v, b_v, c_v;
  logic [CW-1:0]          a_idx;
  logic [VOL_W-1:0]       b_vol;
  logic [15:0]            prod;

  logic [NW-1:0]          n_used;
  logic [5:0]             cc6;
  logic                   ch_ok;
  logic [CW-1:0]          ch_idx;
  logic [CW-1:0]          idx_c;
  logic                   idx_last;

  logic                   chan_we;
  logic [CW-1:0]          chan_waddr;
  logic [ENTRY_W-1:0]     chan_wdata;
  logic [CW-1:0]          chan_raddr;
  logic [ENTRY_W-1:0]     chan_rdata;
  chan_entry_t            ent;
  chan_entry_t            ent_upd;
  chan_entry_t            ent_rmw;
  logic [LEN_W-1:0]       pos_inc;
  logic                   end_hit;
  logic [AW-1:0]          start_ptr;

  logic                   smp_we;
  logic [SMP_W-1:0]       smp_rdata;

  logic                   div_start;
  logic                   div_done;
  logic [7:0]             div_q;
  logic [DIV_W-1:0]       divisor;

  always_comb begin
    cc6 = 6'(channel_count);
    if (cc6 == 6'd0) begin
      n_used = NW'(1);
    end else if (cc6 > MAXC6) begin
      n_used = NW'(MAX_CHANNELS);
    end else begin
      n_used = NW'(cc6);
    end
  end

  assign ch_ok    = 6'(req_q.channel) < MAXC6;
  assign ch_idx   = CW'(req_q.channel);
  assign idx_c    = CW'(idx);
  assign idx_last = (idx == n_used - 1'b1);
  assign req_stall = (state != S_IDLE);

  // Channel table: read-modify-write for play and volume, write-back of the tick walk.
  assign ent       = chan_entry_t'(chan_rdata);
  assign start_ptr = wrap_addr(req_q.sample_address);
  assign pos_inc   = ent.pos + 1'b1;
  assign end_hit   = (pos_inc >= ent.length);

  always_comb begin
    ent_upd = ent;
    if (end_hit) begin
      ent_upd.pos = '0;
      ent_upd.ptr = ent.start;
    end else begin
      ent_upd.pos = pos_inc;
      ent_upd.ptr = (ent.ptr == LAST_ADDR) ? '0 : ent.ptr + 1'b1;
    end
  end

  always_comb begin
    ent_rmw = ent;
    if (req_q.opcode == OP_PLAY) begin
      ent_rmw.ptr    = start_ptr;
      ent_rmw.start  = start_ptr;
      ent_rmw.length = req_q.sample_length;
      ent_rmw.loops  = req_q.repeat_req;
      ent_rmw.pos    = '0;
    end else begin
      ent_rmw.vol    = req_q.volume;
    end
  end

  assign chan_raddr = (state == S_TICK) ? idx_c : ch_idx;
  assign chan_we    = a_v || (state == S_RMW);
  assign chan_waddr = a_v ? a_idx : ch_idx;
  assign chan_wdata = a_v ? ENTRY_W'(ent_upd) : ENTRY_W'(ent_rmw);

  assign smp_we = (state == S_EXEC) && (req_q.opcode == OP_WRITE);

  assign divisor   = DIV_W'({n_used, 8'b0}) - DIV_W'(n_used);
  assign div_start = (state == S_DRAIN) && !a_v && !b_v && !c_v;

  msm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .raddr (chan_raddr),
    .rdata (chan_rdata)
  );

  msm_ram #(
    .WIDTH(SMP_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (start_ptr),
    .wdata (req_q.sample_value),
    .raddr (ent.ptr),
    .rdata (smp_rdata)
  );

  msm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Payload side of the tick pipeline.
  always_ff @(posedge clk) begin
    if (state == S_TICK) begin
      a_idx <= idx_c;
    end
    if (a_v) begin
      b_vol <= vol_set[a_idx] ? ent.vol : FULL_SCALE;
    end
    prod <= 16'(smp_rdata) * 16'(b_vol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      channel_count <= CNT_CFG_W'(8);
      playing       <= '0;
      paused        <= '0;
      vol_set       <= '0;
      play_cnt      <= '0;
      dac_hold      <= '0;
      rsp_valid     <= 1'b0;
      a_v           <= 1'b0;
      b_v           <= 1'b0;
      c_v           <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        channel_count <= cfg_wr_data;
      end
      // In S_DONE the response register is reloaded below instead.
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      a_v <= 1'b0;
      b_v <= a_v;
      c_v <= b_v;
      if (c_v) begin
        sum <= sum + SUM_W'(prod);
      end
      // A sound that ends without looping stops its channel during the walk.
      if (a_v && end_hit && !ent.loops) begin
        playing[a_idx] <= 1'b0;
        play_cnt       <= play_cnt - 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q     <= req;
            changed_q <= 1'b0;
            idx       <= '0;
            state     <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_DONE;
          case (req_q.opcode)
            OP_TICK: begin
              if (play_cnt != '0) begin
                sum   <= '0;
                state <= S_TICK;
              end
            end
            OP_PLAY: begin
              if (ch_ok) begin
                // A restart of the only playing channel still drops the DAC to zero.
                if (playing[ch_idx]) begin
                  if (play_cnt == NW'(1)) begin
                    dac_hold <= '0;
                  end
                end else begin
                  play_cnt <= play_cnt + 1'b1;
                end
                playing[ch_idx] <= 1'b1;
                paused[ch_idx]  <= 1'b0;
                state           <= S_RMW;
              end
            end
            OP_STOP: begin
              if (ch_ok) begin
                changed_q <= playing[ch_idx] || paused[ch_idx];
                if (playing[ch_idx]) begin
                  play_cnt <= play_cnt - 1'b1;
                  if (play_cnt == NW'(1)) begin
                    dac_hold <= '0;
                  end
                end
                playing[ch_idx] <= 1'b0;
                paused[ch_idx]  <= 1'b0;
              end
            end
            OP_PAUSE: begin
              if (ch_ok) begin
                changed_q <= 1'b1;
                if (playing[ch_idx]) begin
                  playing[ch_idx] <= 1'b0;
                  paused[ch_idx]  <= 1'b1;
                  play_cnt        <= play_cnt - 1'b1;
                  if (play_cnt == NW'(1)) begin
                    dac_hold <= '0;
                  end
                end
              end
            end
            OP_RESUME: begin
              if (ch_ok) begin
                changed_q <= 1'b1;
                if (paused[ch_idx]) begin
                  paused[ch_idx]  <= 1'b0;
                  playing[ch_idx] <= 1'b1;
                  play_cnt        <= play_cnt + 1'b1;
                end
              end
            end
            OP_STOP_ALL, OP_PAUSE_ALL, OP_RESUME_ALL: begin
              changed_q <= (req_q.opcode != OP_STOP_ALL);
              state     <= S_ALL;
            end
            OP_SET_VOLUME: begin
              if (ch_ok) begin
                vol_set[ch_idx] <= 1'b1;
                state           <= S_RMW;
              end
            end
            default: begin
            end
          endcase
        end

        S_RMW: begin
          state <= S_DONE;
        end

        S_ALL: begin
          case (req_q.opcode)
            OP_STOP_ALL: begin
              if (playing[idx_c] || paused[idx_c]) begin
                changed_q <= 1'b1;
              end
              if (playing[idx_c]) begin
                play_cnt <= play_cnt - 1'b1;
                if (play_cnt == NW'(1)) begin
                  dac_hold <= '0;
                end
              end
              playing[idx_c] <= 1'b0;
              paused[idx_c]  <= 1'b0;
            end
            OP_PAUSE_ALL: begin
              if (playing[idx_c]) begin
                playing[idx_c] <= 1'b0;
                paused[idx_c]  <= 1'b1;
                play_cnt       <= play_cnt - 1'b1;
                if (play_cnt == NW'(1)) begin
                  dac_hold <= '0;
                end
              end
            end
            OP_RESUME_ALL: begin
              if (paused[idx_c]) begin
                paused[idx_c]  <= 1'b0;
                playing[idx_c] <= 1'b1;
                play_cnt       <= play_cnt + 1'b1;
              end
            end
            default: begin
            end
          endcase
          idx <= idx + 1'b1;
          if (idx_last) begin
            state <= S_DONE;
          end
        end

        S_TICK: begin
          a_v <= playing[idx_c];
          idx <= idx + 1'b1;
          if (idx_last) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            dac_hold <= div_q;
            state    <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid         <= 1'b1;
            rsp.dac_level     <= dac_hold;
            rsp.changed       <= changed_q;
            rsp.running       <= (play_cnt != '0);
            if (ch_ok && playing[ch_idx]) begin
              rsp.channel_state <= CH_PLAYING;
            end else if (ch_ok && paused[ch_idx]) begin
              rsp.channel_state <= CH_PAUSED;
            end else begin
              rsp.channel_state <= CH_STOPPED;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/msm_check.sv */
// Port-level checker for the sample mixer, bound to the top level below.
// Depends on msm_pkg and the assertion macros in multichannel_sample_mixer_defines.svh.
`timescale 1ns / 1ps
`include "multichannel_sample_mixer_defines.svh"

module msm_check import msm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A response held back by the receiver keeps its value.
  `MSM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

  // Only one request is worked at a time.
  `MSM_ASSERT_NEXT(a_one_request, clk, rst, req_valid && !req_stall, req_stall, "request taken while busy")

  // A channel reported as playing means the mixer is running.
  `MSM_ASSERT_NOW(a_play_running, clk, rst, rsp_valid && (rsp.channel_state == CH_PLAYING), rsp.running, "playing channel without running mixer")

  // Reset leaves the block ready with no pending response.
  `MSM_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !rsp_valid && !req_stall, "not quiet after reset")

endmodule

bind multichannel_sample_mixer msm_check u_msm_check (.*);

/* dv/multichannel_sample_mixer_test.sv */
// Self-checking testbench for the multichannel sample mixer: a directed script, then
// random command streams under several channel counts and handshake pressures.
// Depends on msm_pkg and the multichannel_sample_mixer RTL.
`timescale 1ns / 1ps

module multichannel_sample_mixer_test;
  import msm_pkg::*;

  localparam int CHANNELS = 8;
  localparam int MEM_DEPTH = 16384;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 62;
  localparam int MAX_PRINTED = 20;
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CNT_CFG_W-1:0] cfg_wr_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;

  multichannel_sample_mixer dut (
    .clk,
    .rst,
    .cfg_wr_en,
    .cfg_wr_data,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  always #2 clk = ~clk;

  // Mixer state as the predictor sees it.
  logic [7:0]  smp_mem     [MEM_DEPTH];
  bit          smp_written [MEM_DEPTH];
  logic [13:0] snd_start   [CHANNELS];
  logic [14:0] snd_len     [CHANNELS];
  bit          snd_loop    [CHANNELS];
  logic [14:0] snd_pos     [CHANNELS];
  logic [7:0]  ch_vol      [CHANNELS];
  bit          ch_play     [CHANNELS];
  bit          ch_pause    [CHANNELS];
  int          n_playing;
  logic [7:0]  dac_now;
  logic [3:0]  mix_count_reg;

  rsp_t mix_expected[$];

  typedef struct {
    req_t cmd;
    bit   fixed;
    rsp_t want;
  } step_row_t;

  step_row_t script[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int reqs_sent = 0;
  int rsps_checked = 0;
  int ticks_mixed = 0;
  int quiet_cycles = 0;

  function automatic void reset_mixer_model();
    int i;
    for (i = 0; i < MEM_DEPTH; i++) begin
      smp_mem[i] = 8'd0;
      smp_written[i] = 1'b0;
    end
    for (i = 0; i < CHANNELS; i++) begin
      snd_start[i] = '0;
      snd_len[i] = '0;
      snd_loop[i] = 1'b0;
      snd_pos[i] = '0;
      ch_vol[i] = FULL_SCALE;
      ch_play[i] = 1'b0;
      ch_pause[i] = 1'b0;
    end
    n_playing = 0;
    dac_now = 8'd0;
    mix_count_reg = 4'd8;
  endfunction

  function automatic int mix_width();
    if (mix_count_reg == 4'd0) return 1;
    if (mix_count_reg > CHANNELS) return CHANNELS;
    return int'(mix_count_reg);
  endfunction

  // The DAC drops to zero the moment the last playing channel goes away.
  function automatic void drop_player();
    if (n_playing > 0) begin
      n_playing--;
      if (n_playing == 0) dac_now = 8'd0;
    end
  endfunction

  function automatic bit halt_channel(int c);
    bit was;
    was = ch_play[c] || ch_pause[c];
    if (ch_play[c]) drop_player();
    ch_play[c] = 1'b0;
    ch_pause[c] = 1'b0;
    return was;
  endfunction

  function automatic void hold_channel(int c);
    if (ch_play[c]) begin
      ch_play[c] = 1'b0;
      ch_pause[c] = 1'b1;
      drop_player();
    end
  endfunction

  function automatic void release_channel(int c);
    if (ch_pause[c]) begin
      ch_pause[c] = 1'b0;
      ch_play[c] = 1'b1;
      n_playing++;
    end
  endfunction

  function automatic rsp_t mixer_step(req_t r);
    rsp_t o;
    int n;
    int i;
    int unsigned a;
    int unsigned sum;
    bit chg;
    n = mix_width();
    chg = 1'b0;
    case (r.opcode)
      OP_TICK: begin
        if (n_playing != 0) begin
          ticks_mixed++;
          sum = 0;
          for (i = 0; i < n; i++) begin
            if (ch_play[i]) begin
              a = (int'(snd_start[i]) + int'(snd_pos[i])) % MEM_DEPTH;
              sum += int'(smp_mem[a]) * int'(ch_vol[i]);
              snd_pos[i] = snd_pos[i] + 15'd1;
              if (snd_pos[i] >= snd_len[i]) begin
                if (snd_loop[i]) snd_pos[i] = 15'd0;
                else void'(halt_channel(i));
              end
            end
          end
          sum = sum / 255 / n;
          // The mixed level lands after any forced zero from a channel ending.
          dac_now = (sum > 255) ? 8'd255 : 8'(sum);
        end
      end
      OP_WRITE: begin
        smp_mem[r.sample_address] = r.sample_value;
        smp_written[r.sample_address] = 1'b1;
      end
      OP_PLAY: begin
        void'(halt_channel(r.channel));
        snd_start[r.channel] = r.sample_address;
        snd_len[r.channel] = r.sample_length;
        snd_loop[r.channel] = r.repeat_req;
        snd_pos[r.channel] = 15'd0;
        ch_play[r.channel] = 1'b1;
        n_playing++;
      end
      OP_STOP: chg = halt_channel(r.channel);
      OP_PAUSE: begin
        hold_channel(r.channel);
        chg = 1'b1;
      end
      OP_RESUME: begin
        release_channel(r.channel);
        chg = 1'b1;
      end
      OP_STOP_ALL: begin
        for (i = 0; i < n; i++) if (halt_channel(i)) chg = 1'b1;
      end
      OP_PAUSE_ALL: begin
        for (i = 0; i < n; i++) hold_channel(i);
        chg = 1'b1;
      end
      OP_RESUME_ALL: begin
        for (i = 0; i < n; i++) release_channel(i);
        chg = 1'b1;
      end
      OP_SET_VOLUME: ch_vol[r.channel] = r.volume;
      default: ;
    endcase
    o.dac_level = dac_now;
    o.channel_state = ch_play[r.channel] ? CH_PLAYING :
                      ch_pause[r.channel] ? CH_PAUSED : CH_STOPPED;
    o.changed = chg;
    o.running = (n_playing != 0);
    return o;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (mix_expected.size() == 0) begin
      flag_mismatch("response arrived with no request outstanding");
      return;
    end
    want = mix_expected.pop_front();
    if (got.dac_level !== want.dac_level)
      flag_mismatch($sformatf("response %0d dac_level %0d, expected %0d",
                              rsps_checked, got.dac_level, want.dac_level));
    if (got.channel_state !== want.channel_state)
      flag_mismatch($sformatf("response %0d channel_state %0d, expected %0d",
                              rsps_checked, got.channel_state, want.channel_state));
    if (got.changed !== want.changed)
      flag_mismatch($sformatf("response %0d changed %0b, expected %0b",
                              rsps_checked, got.changed, want.changed));
    if (got.running !== want.running)
      flag_mismatch($sformatf("response %0d running %0b, expected %0b",
                              rsps_checked, got.running, want.running));
    rsps_checked++;
  endtask

  // Response side: checks what was taken at this edge, then picks the next stall.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) check_response(rsp);
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request or response moved for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Drives one request and returns at the edge that accepts it. Valid is left high
  // so a back-to-back request does not toggle it within one step.
  task automatic issue(input req_t r, input bit fixed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = mixer_step(r);
    mix_expected.push_back(fixed ? want : predicted);
    reqs_sent++;
  endtask

  task automatic load_channel_count(input logic [3:0] value);
    req_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mix_count_reg = value;
  endtask

  function automatic void add_step(logic [3:0] op, logic [2:0] ch, logic [13:0] addr,
                                   logic [14:0] len, logic rep, logic [7:0] val,
                                   logic [7:0] vol, bit fixed = 1'b0, rsp_t want = '0);
    step_row_t row;
    row.cmd = req_t'{op, ch, addr, len, rep, val, vol};
    row.fixed = fixed;
    row.want = want;
    script.push_back(row);
  endfunction

  function automatic void build_script();
    // Idle block: nothing plays, so every level is zero.
    add_step(OP_QUERY, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b0, 1'b0});
    add_step(OP_TICK, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b0, 1'b0});
    add_step(OP_STOP, 3'd3, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b0, 1'b0});
    add_step(OP_PAUSE, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b1, 1'b0});
    add_step(OP_RESUME, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b1, 1'b0});
    add_step(OP_UNUSED_LAST, 3'd7, 14'h3fff, 15'h7fff, 1'b1, 8'hff, 8'hff, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b0, 1'b0});
    add_step(OP_WRITE, 3'd0, 14'd0, 15'd0, 1'b0, 8'd255, 8'd0);
    add_step(OP_WRITE, 3'd0, 14'd16383, 15'd0, 1'b0, 8'd255, 8'd0);
    add_step(OP_WRITE, 3'd0, 14'd1, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_WRITE, 3'd0, 14'd2, 15'd0, 1'b0, 8'd128, 8'd0);
    // Channel 0 starts at the last byte, so its second sample wraps to address 0.
    add_step(OP_PLAY, 3'd0, 14'd16383, 15'd3, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_PLAYING, 1'b0, 1'b1});
    // A zero-length sound still plays its first sample, then loops.
    add_step(OP_PLAY, 3'd7, 14'd0, 15'd0, 1'b1, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_PLAYING, 1'b0, 1'b1});
    add_step(OP_SET_VOLUME, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_TICK, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_TICK, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_TICK, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_PAUSE_ALL, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_QUERY, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_PAUSED, 1'b0, 1'b0});
    add_step(OP_RESUME_ALL, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_SET_VOLUME, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd255);
    add_step(OP_TICK, 3'd7, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_PLAY, 3'd1, 14'd2, 15'h7fff, 1'b0, 8'd0, 8'd0);
    add_step(OP_PAUSE, 3'd1, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    // Stopping a paused channel must not take the playing count down twice.
    add_step(OP_STOP, 3'd1, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_STOP_ALL, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
    add_step(OP_STOP_ALL, 3'd0, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0, 1'b1,
             rsp_t'{8'd0, CH_STOPPED, 1'b0, 1'b0});
    add_step(OP_PLAY, 3'd2, 14'd5, 15'd16384, 1'b1, 8'd0, 8'd0);
    add_step(OP_STOP, 3'd2, 14'd0, 15'd0, 1'b0, 8'd0, 8'd0);
  endfunction

  // A tick must never read a sample byte that was never written, so any byte
  // the coming tick will fetch is written first with random content.
  task automatic fill_tick_sources();
    req_t w;
    int a;
    int i;
    for (i = 0; i < mix_width(); i++) begin
      if (ch_play[i]) begin
        a = (int'(snd_start[i]) + int'(snd_pos[i])) % MEM_DEPTH;
        if (!smp_written[a]) begin
          w = '0;
          w.opcode = OP_WRITE;
          w.channel = 3'($urandom_range(7));
          w.sample_address = 14'(a);
          w.sample_value = 8'($urandom_range(255));
          issue(w, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic issue_random();
    req_t r;
    int pick;
    int n;
    n = mix_width();
    pick = $urandom_range(99);
    r.channel = ($urandom_range(9) < 8) ? 3'($urandom_range(n - 1)) : 3'($urandom_range(7));
    r.sample_address = 14'($urandom_range(MEM_DEPTH - 1));
    if ($urandom_range(99) < 85) r.sample_length = 15'($urandom_range(12));
    else if ($urandom_range(1) == 0) r.sample_length = 15'd16384;
    else r.sample_length = 15'($urandom_range(32767));
    r.repeat_req = 1'($urandom_range(1));
    r.sample_value = 8'($urandom_range(255));
    r.volume = 8'($urandom_range(255));
    if (pick < 35) r.opcode = OP_TICK;
    else if (pick < 45) r.opcode = OP_WRITE;
    else if (pick < 60) r.opcode = OP_PLAY;
    else if (pick < 67) r.opcode = OP_STOP;
    else if (pick < 73) r.opcode = OP_PAUSE;
    else if (pick < 79) r.opcode = OP_RESUME;
    else if (pick < 81) r.opcode = OP_STOP_ALL;
    else if (pick < 84) r.opcode = OP_PAUSE_ALL;
    else if (pick < 87) r.opcode = OP_RESUME_ALL;
    else if (pick < 95) r.opcode = OP_SET_VOLUME;
    else if (pick < 98) r.opcode = OP_QUERY;
    else r.opcode = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    if (r.opcode == OP_TICK) fill_tick_sources();
    issue(r, 1'b0, '0);
  endtask

  initial begin
    logic [3:0] counts [8];
    int p;
    int phase_end;
    counts = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7};
    reset_mixer_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    build_script();
    foreach (script[k]) issue(script[k].cmd, script[k].fixed, script[k].want);
    for (p = 0; p < 8; p++) begin
      load_channel_count(counts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      // Sample writes that prepare a tick count toward the phase budget.
      phase_end = reqs_sent + PHASE_ITEMS;
      while (reqs_sent < phase_end) issue_random();
    end
    req_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d mixed ticks) and checked %0d responses,",
             reqs_sent, ticks_mixed, rsps_checked);
    $display("over channel counts 0 to 15 with sender gaps and receiver stalls.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
